// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the RTL top level. Every check is disabled while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked a fixed number of cycles later.
`define ASSERT_DELAYED(label, clk, rst_n, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

// ===== rtl/qvr_pkg.sv =====
package qvr_pkg;

    localparam int QUAT_W = 16;
    localparam int TOL_W = 29;
    localparam int VEC_WIDTH_DEF = 24;
    localparam int QUAT_FRAC_BITS_DEF = 14;
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(65536);

    typedef struct packed {
        logic signed [QUAT_W-1:0] w;
        logic signed [QUAT_W-1:0] i;
        logic signed [QUAT_W-1:0] j;
        logic signed [QUAT_W-1:0] k;
    } quat_t;

    // Width of one component of v * conj(q): a sum of three vector-by-quaternion products.
    function automatic int p_width(int vec_w);
        return vec_w + QUAT_W + 2;
    endfunction

    // Width of one vector component of q * p before rounding, with room for the rounding offset.
    function automatic int sum_width(int vec_w, int frac_bits);
        int w_sum;
        w_sum = p_width(vec_w) + QUAT_W + 2;
        return (w_sum > 2 * frac_bits + 2) ? w_sum : 2 * frac_bits + 2;
    endfunction

endpackage

// ===== rtl/quaternion_vector_rotation_unit.sv =====
// Rotates a signed integer vector by a Q1.14 quaternion as q * v * conj(q), with rounding to
// nearest (ties upward) and saturation to the vector width. A transaction is accepted on every
// cycle in which start is high; busy never rises, so one item per clock is sustained. The
// result appears on rot_x, rot_y, rot_z and not_unit for exactly one cycle, marked by done.
// The datapath is a six-register pipeline: input capture, the v * conj(q) multipliers,
// their sums with the norm check, the q * p multipliers, the rounding sums and the
// saturating output register. There is no stall path: results must be taken as they
// appear. When the squared norm exceeds one by more than the tolerance set through
// cfg_wdata (units of 2^-28), the input vector is returned unchanged with not_unit set.
// A norm below one is not flagged. Write cfg_wdata with cfg_we only while no
// transaction is in flight.
`include "assert_macros.svh"

module quaternion_vector_rotation_unit #(
    parameter int VEC_WIDTH = qvr_pkg::VEC_WIDTH_DEF,
    parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [qvr_pkg::QUAT_W-1:0]  quat_w,
    input  logic signed [qvr_pkg::QUAT_W-1:0]  quat_i,
    input  logic signed [qvr_pkg::QUAT_W-1:0]  quat_j,
    input  logic signed [qvr_pkg::QUAT_W-1:0]  quat_k,
    input  logic signed [VEC_WIDTH-1:0]        vec_x,
    input  logic signed [VEC_WIDTH-1:0]        vec_y,
    input  logic signed [VEC_WIDTH-1:0]        vec_z,
    input  logic                               cfg_we,
    input  logic [qvr_pkg::TOL_W-1:0]          cfg_wdata,
    output logic                               done,
    output logic signed [VEC_WIDTH-1:0]        rot_x,
    output logic signed [VEC_WIDTH-1:0]        rot_y,
    output logic signed [VEC_WIDTH-1:0]        rot_z,
    output logic                               not_unit
);

    localparam int PW = qvr_pkg::p_width(VEC_WIDTH);
    localparam int LATENCY = 6;

    logic [qvr_pkg::TOL_W-1:0]    tol_reg;
    logic [qvr_pkg::TOL_W-1:0]    tol_next;

    logic                         in_valid_reg;
    logic                         in_valid_next;
    qvr_pkg::quat_t               quat_in_reg;
    qvr_pkg::quat_t               quat_in_next;
    logic signed [VEC_WIDTH-1:0]  vec_in_reg [3];
    logic signed [VEC_WIDTH-1:0]  vec_in_next [3];

    logic                         mid_valid;
    qvr_pkg::quat_t               mid_quat;
    logic signed [PW-1:0]         mid_p [4];
    logic signed [VEC_WIDTH-1:0]  mid_vec [3];
    logic                         mid_not_unit;

    logic signed [VEC_WIDTH-1:0]  rot [3];

    assign busy = 1'b0;

    always_comb
    begin
        tol_next = cfg_we ? cfg_wdata : tol_reg;
        in_valid_next = start && !busy;
        quat_in_next.w = quat_w;
        quat_in_next.i = quat_i;
        quat_in_next.j = quat_j;
        quat_in_next.k = quat_k;
        vec_in_next[0] = vec_x;
        vec_in_next[1] = vec_y;
        vec_in_next[2] = vec_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg      <= qvr_pkg::TOL_RESET;
            in_valid_reg <= 1'b0;
        end
        else
        begin
            tol_reg      <= tol_next;
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quat_in_reg <= quat_in_next;
        vec_in_reg  <= vec_in_next;
    end

    qvr_vq_stage #(
        .VEC_WIDTH      (VEC_WIDTH),
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_vq_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid_reg),
        .in_quat      (quat_in_reg),
        .in_vec       (vec_in_reg),
        .tol          (tol_reg),
        .out_valid    (mid_valid),
        .out_quat     (mid_quat),
        .out_p        (mid_p),
        .out_vec      (mid_vec),
        .out_not_unit (mid_not_unit)
    );

    qvr_qp_stage #(
        .VEC_WIDTH      (VEC_WIDTH),
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_qp_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (mid_valid),
        .in_quat      (mid_quat),
        .in_p         (mid_p),
        .in_vec       (mid_vec),
        .in_not_unit  (mid_not_unit),
        .out_valid    (done),
        .out_rot      (rot),
        .out_not_unit (not_unit)
    );

    assign rot_x = rot[0];
    assign rot_y = rot[1];
    assign rot_z = rot[2];

    // Every accepted transaction produces exactly one result after the pipeline latency.
    `ASSERT_DELAYED(a_start_gives_done, clk, rst_n, start && !busy, LATENCY, done, "accepted transaction produced no result")
    `ASSERT_IMPLIES(a_done_from_start, clk, rst_n, done, $past(start && !busy, LATENCY), "result without an accepted transaction")
    // A flagged result carries the vector exactly as it was presented.
    `ASSERT_IMPLIES(a_pass_through, clk, rst_n, done && not_unit, (rot_x == $past(vec_x, LATENCY)) && (rot_y == $past(vec_y, LATENCY)) && (rot_z == $past(vec_z, LATENCY)), "flagged result differs from input vector")

endmodule

// ===== rtl/qvr_vq_stage.sv =====
module qvr_vq_stage #(
    parameter int VEC_WIDTH = qvr_pkg::VEC_WIDTH_DEF,
    parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           in_valid,
    input  qvr_pkg::quat_t                                 in_quat,
    input  logic signed [VEC_WIDTH-1:0]                    in_vec [3],
    input  logic [qvr_pkg::TOL_W-1:0]                      tol,
    output logic                                           out_valid,
    output qvr_pkg::quat_t                                 out_quat,
    output logic signed [qvr_pkg::p_width(VEC_WIDTH)-1:0]  out_p [4],
    output logic signed [VEC_WIDTH-1:0]                    out_vec [3],
    output logic                                           out_not_unit
);

    localparam int QW = qvr_pkg::QUAT_W;
    localparam int MW = VEC_WIDTH + QW;
    localparam int PW = qvr_pkg::p_width(VEC_WIDTH);
    localparam int SQW = 2 * QW;
    localparam int EXC_W = (2 * QUAT_FRAC_BITS + 2 > 2 * QW + 3) ?
                           2 * QUAT_FRAC_BITS + 2 : 2 * QW + 3;
    localparam logic signed [EXC_W-1:0] NORM_ONE =
        {{(EXC_W-1){1'b0}}, 1'b1} << (2 * QUAT_FRAC_BITS);

    // Stage one: all vector-by-quaternion products and the four squares.
    logic                         valid_s1_reg;
    logic                         valid_s1_next;
    logic signed [MW-1:0]         prod_reg [3][4];
    logic signed [MW-1:0]         prod_next [3][4];
    logic signed [SQW-1:0]        sq_reg [4];
    logic signed [SQW-1:0]        sq_next [4];
    qvr_pkg::quat_t               quat_s1_reg;
    logic signed [VEC_WIDTH-1:0]  vec_s1_reg [3];

    // Stage two: components of v * conj(q) and the norm verdict.
    logic                         valid_s2_reg;
    logic signed [PW-1:0]         p_reg [4];
    logic signed [PW-1:0]         p_next [4];
    logic                         not_unit_reg;
    logic                         not_unit_next;
    qvr_pkg::quat_t               quat_s2_reg;
    logic signed [VEC_WIDTH-1:0]  vec_s2_reg [3];

    always_comb
    begin
        logic signed [QW-1:0] qc [4];
        qc[0] = in_quat.w;
        qc[1] = in_quat.i;
        qc[2] = in_quat.j;
        qc[3] = in_quat.k;
        valid_s1_next = in_valid;
        for (int v = 0; v < 3; v++)
        begin
            for (int n = 0; n < 4; n++)
            begin
                prod_next[v][n] = MW'(in_vec[v]) * MW'(qc[n]);
            end
        end
        for (int n = 0; n < 4; n++)
        begin
            sq_next[n] = SQW'(qc[n]) * SQW'(qc[n]);
        end
    end

    always_comb
    begin
        logic signed [PW-1:0]    pe [3][4];
        logic signed [EXC_W-1:0] norm2;
        logic signed [EXC_W-1:0] excess;
        for (int v = 0; v < 3; v++)
        begin
            for (int n = 0; n < 4; n++)
            begin
                pe[v][n] = PW'(prod_reg[v][n]);
            end
        end
        // Index order: vector x, y, z; quaternion w, i, j, k.
        p_next[0] =  pe[0][1] + pe[1][2] + pe[2][3];
        p_next[1] =  pe[0][0] - pe[1][3] + pe[2][2];
        p_next[2] =  pe[0][3] + pe[1][0] - pe[2][1];
        p_next[3] = -pe[0][2] + pe[1][1] + pe[2][0];
        norm2 = EXC_W'(sq_reg[0]) + EXC_W'(sq_reg[1]) + EXC_W'(sq_reg[2])
              + EXC_W'(sq_reg[3]);
        excess = norm2 - NORM_ONE;
        // One-sided: a norm below one always rotates.
        not_unit_next = excess > $signed({{(EXC_W-qvr_pkg::TOL_W){1'b0}}, tol});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_s1_reg <= 1'b0;
            valid_s2_reg <= 1'b0;
        end
        else
        begin
            valid_s1_reg <= valid_s1_next;
            valid_s2_reg <= valid_s1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        sq_reg       <= sq_next;
        quat_s1_reg  <= in_quat;
        vec_s1_reg   <= in_vec;
        p_reg        <= p_next;
        not_unit_reg <= not_unit_next;
        quat_s2_reg  <= quat_s1_reg;
        vec_s2_reg   <= vec_s1_reg;
    end

    assign out_valid    = valid_s2_reg;
    assign out_quat     = quat_s2_reg;
    assign out_p        = p_reg;
    assign out_vec      = vec_s2_reg;
    assign out_not_unit = not_unit_reg;

endmodule

// ===== rtl/qvr_qp_stage.sv =====
module qvr_qp_stage #(
    parameter int VEC_WIDTH = qvr_pkg::VEC_WIDTH_DEF,
    parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           in_valid,
    input  qvr_pkg::quat_t                                 in_quat,
    input  logic signed [qvr_pkg::p_width(VEC_WIDTH)-1:0]  in_p [4],
    input  logic signed [VEC_WIDTH-1:0]                    in_vec [3],
    input  logic                                           in_not_unit,
    output logic                                           out_valid,
    output logic signed [VEC_WIDTH-1:0]                    out_rot [3],
    output logic                                           out_not_unit
);

    localparam int QW = qvr_pkg::QUAT_W;
    localparam int PW = qvr_pkg::p_width(VEC_WIDTH);
    localparam int MW = PW + QW;
    localparam int SW = qvr_pkg::sum_width(VEC_WIDTH, QUAT_FRAC_BITS);
    localparam logic signed [SW-1:0] ROUND_HALF =
        {{(SW-1){1'b0}}, 1'b1} << (2 * QUAT_FRAC_BITS - 1);
    localparam logic signed [SW-1:0] SAT_MAX =
        {{(SW-VEC_WIDTH+1){1'b0}}, {(VEC_WIDTH-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_MIN =
        {{(SW-VEC_WIDTH+1){1'b1}}, {(VEC_WIDTH-1){1'b0}}};
    // Bit n set where the quaternion component n enters the output component with a minus sign.
    localparam logic [3:0] NEG_MASK [3] = '{4'b1000, 4'b0010, 4'b0100};

    // Stage three: products of q with the permuted components of p.
    logic                         valid_s3_reg;
    logic signed [MW-1:0]         rp_reg [3][4];
    logic signed [MW-1:0]         rp_next [3][4];
    logic                         not_unit_s3_reg;
    logic signed [VEC_WIDTH-1:0]  vec_s3_reg [3];

    // Stage four: signed sums with the rounding offset added.
    logic                         valid_s4_reg;
    logic signed [SW-1:0]         sum_reg [3];
    logic signed [SW-1:0]         sum_next [3];
    logic                         not_unit_s4_reg;
    logic signed [VEC_WIDTH-1:0]  vec_s4_reg [3];

    // Stage five: scaled, saturated result or the pass-through vector.
    logic                         valid_out_reg;
    logic signed [VEC_WIDTH-1:0]  rot_reg [3];
    logic signed [VEC_WIDTH-1:0]  rot_next [3];
    logic                         not_unit_out_reg;

    always_comb
    begin
        logic signed [QW-1:0] qc [4];
        logic [1:0]           pi;
        qc[0] = in_quat.w;
        qc[1] = in_quat.i;
        qc[2] = in_quat.j;
        qc[3] = in_quat.k;
        // Output component r pairs quaternion part n with p[n xor (r+1)].
        for (int r = 0; r < 3; r++)
        begin
            for (int n = 0; n < 4; n++)
            begin
                pi = 2'(n) ^ 2'(r + 1);
                rp_next[r][n] = MW'(qc[n]) * MW'(in_p[pi]);
            end
        end
    end

    always_comb
    begin
        logic signed [SW-1:0] acc;
        for (int r = 0; r < 3; r++)
        begin
            acc = ROUND_HALF;
            for (int n = 0; n < 4; n++)
            begin
                if (NEG_MASK[r][n])
                begin
                    acc = acc - SW'(rp_reg[r][n]);
                end
                else
                begin
                    acc = acc + SW'(rp_reg[r][n]);
                end
            end
            sum_next[r] = acc;
        end
    end

    always_comb
    begin
        logic signed [SW-1:0] scaled;
        for (int r = 0; r < 3; r++)
        begin
            scaled = sum_reg[r] >>> (2 * QUAT_FRAC_BITS);
            if (not_unit_s4_reg)
            begin
                rot_next[r] = vec_s4_reg[r];
            end
            else if (scaled > SAT_MAX)
            begin
                rot_next[r] = SAT_MAX[VEC_WIDTH-1:0];
            end
            else if (scaled < SAT_MIN)
            begin
                rot_next[r] = SAT_MIN[VEC_WIDTH-1:0];
            end
            else
            begin
                rot_next[r] = scaled[VEC_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_s3_reg  <= 1'b0;
            valid_s4_reg  <= 1'b0;
            valid_out_reg <= 1'b0;
        end
        else
        begin
            valid_s3_reg  <= in_valid;
            valid_s4_reg  <= valid_s3_reg;
            valid_out_reg <= valid_s4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rp_reg           <= rp_next;
        not_unit_s3_reg  <= in_not_unit;
        vec_s3_reg       <= in_vec;
        sum_reg          <= sum_next;
        not_unit_s4_reg  <= not_unit_s3_reg;
        vec_s4_reg       <= vec_s3_reg;
        rot_reg          <= rot_next;
        not_unit_out_reg <= not_unit_s4_reg;
    end

    assign out_valid    = valid_out_reg;
    assign out_rot      = rot_reg;
    assign out_not_unit = not_unit_out_reg;

endmodule

// ===== bench/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VW = qvr_pkg::VEC_WIDTH_DEF;
    localparam int FB = qvr_pkg::QUAT_FRAC_BITS_DEF;
    localparam logic signed [VW-1:0] VEC_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VEC_MIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [qvr_pkg::QUAT_W-1:0] Q_ONE = 16'sd16384;
    localparam logic signed [qvr_pkg::QUAT_W-1:0] Q_MAX = 16'sd32767;
    localparam logic signed [qvr_pkg::QUAT_W-1:0] Q_MIN = -16'sd32768;
    localparam int PHASES = 5;
    localparam int ITEMS_PER_PHASE = 290;

    typedef struct packed {
        qvr_pkg::quat_t q;
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [VW-1:0] z;
    } rot_item_t;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [VW-1:0] z;
        logic not_unit;
    } rot_result_t;

    typedef struct {
        rot_item_t item;
        bit known;
        rot_result_t want;
    } stim_row_t;

    logic clk;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [qvr_pkg::QUAT_W-1:0] quat_w = '0;
    logic signed [qvr_pkg::QUAT_W-1:0] quat_i = '0;
    logic signed [qvr_pkg::QUAT_W-1:0] quat_j = '0;
    logic signed [qvr_pkg::QUAT_W-1:0] quat_k = '0;
    logic signed [VW-1:0] vec_x = '0;
    logic signed [VW-1:0] vec_y = '0;
    logic signed [VW-1:0] vec_z = '0;
    logic cfg_we = 1'b0;
    logic [qvr_pkg::TOL_W-1:0] cfg_wdata = '0;
    logic done;
    logic signed [VW-1:0] rot_x;
    logic signed [VW-1:0] rot_y;
    logic signed [VW-1:0] rot_z;
    logic not_unit;

    logic [qvr_pkg::TOL_W-1:0] tolerance = qvr_pkg::TOL_RESET;
    rot_result_t pending_rotations[$];
    int mismatches = 0;

    // Rows with a typed result are identity, zero, half-turn and flagged cases; the rest go to the predictor.
    stim_row_t directed_rows[20] = '{
        '{'{'{Q_ONE, 0, 0, 0}, 24'sd123, -24'sd456, 24'sd789}, 1'b1,
          '{24'sd123, -24'sd456, 24'sd789, 1'b0}},
        '{'{'{Q_ONE, 0, 0, 0}, VEC_MAX, VEC_MIN, 24'sd0}, 1'b1,
          '{VEC_MAX, VEC_MIN, 24'sd0, 1'b0}},
        '{'{'{Q_ONE, 0, 0, 0}, -24'sd1, 24'sd1, VEC_MIN}, 1'b1,
          '{-24'sd1, 24'sd1, VEC_MIN, 1'b0}},
        '{'{'{0, 0, 0, 0}, VEC_MAX, VEC_MAX, VEC_MIN}, 1'b1,
          '{24'sd0, 24'sd0, 24'sd0, 1'b0}},
        '{'{'{Q_MIN, Q_MIN, Q_MIN, Q_MIN}, 24'sd5, -24'sd6, 24'sd7}, 1'b1,
          '{24'sd5, -24'sd6, 24'sd7, 1'b1}},
        '{'{'{Q_MAX, Q_MAX, Q_MAX, Q_MAX}, VEC_MAX, VEC_MIN, -24'sd1}, 1'b1,
          '{VEC_MAX, VEC_MIN, -24'sd1, 1'b1}},
        '{'{'{-Q_ONE, 0, 0, 0}, 24'sd123, -24'sd456, 24'sd789}, 1'b1,
          '{24'sd123, -24'sd456, 24'sd789, 1'b0}},
        '{'{'{Q_ONE, 16'sd256, 0, 0}, 24'sd1000, -24'sd2000, 24'sd3000}, 1'b0, '0},
        '{'{'{Q_ONE, 16'sd256, 16'sd1, 0}, 24'sd1000, -24'sd2000, 24'sd3000}, 1'b1,
          '{24'sd1000, -24'sd2000, 24'sd3000, 1'b1}},
        '{'{'{0, 0, 0, Q_ONE}, 24'sd100, 24'sd200, 24'sd300}, 1'b1,
          '{-24'sd100, -24'sd200, 24'sd300, 1'b0}},
        '{'{'{0, Q_ONE, 0, 0}, 24'sd100, 24'sd200, 24'sd300}, 1'b0, '0},
        '{'{'{0, 0, Q_ONE, 0}, 24'sd100, 24'sd200, 24'sd300}, 1'b0, '0},
        '{'{'{16'sd11585, 0, 0, 16'sd11585}, 24'sd1000, 24'sd0, -24'sd77}, 1'b0, '0},
        '{'{'{16'sd15137, 0, 0, 16'sd6270}, VEC_MAX, VEC_MAX, 24'sd0}, 1'b0, '0},
        '{'{'{16'sd15137, 0, 0, 16'sd6270}, VEC_MIN, VEC_MIN, 24'sd0}, 1'b0, '0},
        '{'{'{16'sd8192, 0, 0, 0}, 24'sd2, -24'sd2, 24'sd6}, 1'b0, '0},
        '{'{'{16'sd8192, 0, 0, 0}, -24'sd6, 24'sd1, -24'sd1}, 1'b0, '0},
        '{'{'{Q_MIN, 0, 0, 0}, 24'sd9, VEC_MAX, VEC_MIN}, 1'b1,
          '{24'sd9, VEC_MAX, VEC_MIN, 1'b1}},
        '{'{'{0, 0, 0, Q_MIN}, -24'sd1, 24'sd0, VEC_MAX}, 1'b1,
          '{-24'sd1, 24'sd0, VEC_MAX, 1'b1}},
        '{'{'{16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192}, 24'sd1, 24'sd2, 24'sd3}, 1'b0, '0}
    };

    quaternion_vector_rotation_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .quat_w(quat_w),
        .quat_i(quat_i),
        .quat_j(quat_j),
        .quat_k(quat_k),
        .vec_x(vec_x),
        .vec_y(vec_y),
        .vec_z(vec_z),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .done(done),
        .rot_x(rot_x),
        .rot_y(rot_y),
        .rot_z(rot_z),
        .not_unit(not_unit)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Round to nearest with ties upward, then clamp to the vector width.
    function automatic logic signed [VW-1:0] round_saturate(longint s);
        longint r;
        r = (s + (longint'(1) <<< (2*FB - 1))) >>> (2*FB);
        if (r > longint'(VEC_MAX))
            return VEC_MAX;
        if (r < longint'(VEC_MIN))
            return VEC_MIN;
        return r[VW-1:0];
    endfunction

    function automatic rot_result_t rotate_vector(rot_item_t it,
                                                  logic [qvr_pkg::TOL_W-1:0] tol);
        longint w, i, j, k, x, y, z, norm_sq;
        longint p0, p1, p2, p3;
        rot_result_t res;
        w = $signed(it.q.w);
        i = $signed(it.q.i);
        j = $signed(it.q.j);
        k = $signed(it.q.k);
        x = it.x;
        y = it.y;
        z = it.z;
        norm_sq = w*w + i*i + j*j + k*k;
        if (norm_sq - (longint'(1) <<< (2*FB)) > longint'(tol))
        begin
            res = '{it.x, it.y, it.z, 1'b1};
            return res;
        end
        // The vector times the conjugate, kept exact in units of one quaternion LSB.
        p0 = x*i + y*j + z*k;
        p1 = x*w - y*k + z*j;
        p2 = x*k + y*w - z*i;
        p3 = -x*j + y*i + z*w;
        res.x = round_saturate(w*p1 + i*p0 + j*p3 - k*p2);
        res.y = round_saturate(w*p2 - i*p3 + j*p0 + k*p1);
        res.z = round_saturate(w*p3 + i*p2 - j*p1 + k*p0);
        res.not_unit = 1'b0;
        return res;
    endfunction

    // A random direction on the unit sphere, scaled and then nudged by up to nudge LSBs either way.
    function automatic qvr_pkg::quat_t random_attitude(real scale, int nudge);
        real a[4];
        real n;
        int c[4];
        qvr_pkg::quat_t q;
        do
        begin
            foreach (a[m])
                a[m] = $urandom_range(0, 20000) / 10000.0 - 1.0;
            n = $sqrt(a[0]*a[0] + a[1]*a[1] + a[2]*a[2] + a[3]*a[3]);
        end
        while (n < 0.05);
        foreach (c[m])
            c[m] = int'(a[m] / n * 16384.0 * scale) + $urandom_range(0, 2*nudge) - nudge;
        q.w = c[0][qvr_pkg::QUAT_W-1:0];
        q.i = c[1][qvr_pkg::QUAT_W-1:0];
        q.j = c[2][qvr_pkg::QUAT_W-1:0];
        q.k = c[3][qvr_pkg::QUAT_W-1:0];
        return q;
    endfunction

    function automatic rot_item_t random_item();
        logic signed [VW-1:0] extremes[5] = '{VEC_MAX, VEC_MIN, 24'sd0, -24'sd1, 24'sd1};
        logic signed [VW-1:0] v[3];
        int pick;
        int sel;
        rot_item_t it;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            it.q = random_attitude(1.0, 0);
        else if (pick < 67)
            it.q = random_attitude(1.0, 300);
        else if (pick < 77)
            it.q = random_attitude($urandom_range(0, 1000) / 1000.0, 0);
        else
            it.q = qvr_pkg::quat_t'({$urandom, $urandom});
        foreach (v[m])
        begin
            sel = $urandom_range(0, 9);
            if (sel < 6)
                v[m] = VW'($urandom);
            else if (sel < 8)
                v[m] = VW'($urandom_range(0, 2000)) - 24'sd1000;
            else
                v[m] = extremes[$urandom_range(0, 4)];
        end
        it.x = v[0];
        it.y = v[1];
        it.z = v[2];
        return it;
    endfunction

    task automatic idle_gap();
        int n;
        n = $urandom_range(1, 6);
        @(negedge clk) start <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic send_item(rot_item_t it, bit known, rot_result_t want);
        @(negedge clk);
        start <= 1'b1;
        quat_w <= it.q.w;
        quat_i <= it.q.i;
        quat_j <= it.q.j;
        quat_k <= it.q.k;
        vec_x <= it.x;
        vec_y <= it.y;
        vec_z <= it.z;
        do
            @(posedge clk);
        while (busy);
        pending_rotations.push_back(known ? want : rotate_vector(it, tolerance));
    endtask

    // Only written with the pipeline drained, so every transaction in flight saw one setting.
    task automatic write_tolerance(logic [qvr_pkg::TOL_W-1:0] value);
        @(negedge clk) start <= 1'b0;
        while (pending_rotations.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk) cfg_we <= 1'b0;
        tolerance = value;
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : result_check
        rot_result_t want;
        if (rst_n && done)
        begin
            if (pending_rotations.size() == 0)
                report_mismatch("unexpected result", rot_x, 0);
            else
            begin
                want = pending_rotations.pop_front();
                if (rot_x !== want.x)
                    report_mismatch("rot_x", rot_x, want.x);
                if (rot_y !== want.y)
                    report_mismatch("rot_y", rot_y, want.y);
                if (rot_z !== want.z)
                    report_mismatch("rot_z", rot_z, want.z);
                if (not_unit !== want.not_unit)
                    report_mismatch("not_unit", not_unit, want.not_unit);
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("[quaternion_vector_rotation_unit] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        logic [qvr_pkg::TOL_W-1:0] tol_plan[PHASES];
        bit quiet;
        tol_plan[0] = '0;
        tol_plan[1] = qvr_pkg::TOL_W'(268435456);
        tol_plan[2] = '1;
        tol_plan[3] = qvr_pkg::TOL_RESET;
        tol_plan[4] = qvr_pkg::TOL_W'($urandom_range(0, 1 << 22));

        repeat (11) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        foreach (directed_rows[r])
        begin
            if ($urandom_range(0, 99) < 23)
                idle_gap();
            send_item(directed_rows[r].item, directed_rows[r].known, directed_rows[r].want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            write_tolerance(tol_plan[p]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // One long back-to-back burst in the second phase.
                quiet = (p == 1) && (n < 200);
                if (!quiet && $urandom_range(0, 99) < 23)
                    idle_gap();
                send_item(random_item(), 1'b0, '0);
            end
        end

        @(negedge clk) start <= 1'b0;
        while (pending_rotations.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        if (mismatches == 0)
            $display("[quaternion_vector_rotation_unit] OK");
        else
            $display("[quaternion_vector_rotation_unit] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/qvr_pkg.sv
rtl/qvr_vq_stage.sv
rtl/qvr_qp_stage.sv
rtl/quaternion_vector_rotation_unit.sv
bench/testbench.sv
